/* hdl/hiz_pkg.sv */
// hiz_pkg: shared constants for the hierarchical-z max pyramid
// used by hiz_max_depth_pyramid and hiz_checker; no dependencies
package hiz_pkg;
  localparam logic [1:0] StatusQuery    = 2'd0;
  localparam logic [1:0] StatusBuilt    = 2'd1;
  localparam logic [1:0] StatusRejected = 2'd2;
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam int unsigned LevelSlots = 14;
  localparam int unsigned Q16One = 65536;
  localparam logic [3:0] CfgWidth  = 4'd0;
  localparam logic [3:0] CfgHeight = 4'd1;
  // image limits and depth word size
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned DepthBits = 24;
  localparam int unsigned StoreSize =
    (MaxWidth * MaxHeight * 4) / 3 + MaxWidth + MaxHeight + 16;
endpackage

/* hdl/hiz_store.sv */
// hiz_store: single-port depth memory with registered read
// depends on nothing but its parameters
module hiz_store #(
  parameter int unsigned AddrBits = 17,
  parameter int unsigned Depth = 87381,
  parameter int unsigned DataBits = 24
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [DataBits-1:0] wdata_i,
  output logic [DataBits-1:0] rdata_o
);
  logic [DataBits-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* hdl/hiz_max_depth_pyramid.sv */
// hiz_max_depth_pyramid: top level, sequencer for load, build and query
// depends on hiz_pkg and hiz_store
//
// channel   dir  payload
// s_axis    in   tdata: depth_value, left_u, top_v, right_u, bottom_v
//                tuser: cmd; tlast: last_pixel
// m_axis    out  tdata: max_depth; tuser: status
// cfg       in   wr_en, index, data (image_width, image_height)
//
// pixel loads follow back to back; one item is worked at a time
// a query runs StQ0-StQ2, reads each covered texel, answers in StQ3 (StQ2 if empty)
// a build runs StBLvl per level, per texel 4 reads (StBRd, StBAcc) and StBWr
// after reset or a size write the layout is set up level by level, input held off
// the result sits in an output register; a new word is taken once it is free
// no clearing pass after reset; validity is a single flag
module hiz_max_depth_pyramid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // depth_value[23:0], left_u[41:24], top_v[59:42], right_u[77:60],
  // bottom_v[95:78]
  input  logic [95:0]   s_axis_tdata,
  // cmd[0]
  input  logic          s_axis_tuser,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // max_depth[23:0]
  output logic [23:0]   m_axis_tdata,
  // status[1:0]
  output logic [1:0]    m_axis_tuser,
  input  logic          cfg_wr_en_i,
  input  logic [3:0]    cfg_index_i,
  input  logic [8:0]    cfg_data_i
);
  localparam int unsigned StoreSize = hiz_pkg::StoreSize;
  localparam int unsigned AB = $clog2(StoreSize + 1);
  localparam int unsigned DB = hiz_pkg::DepthBits;

  localparam logic [3:0] StIdle = 4'd0, StBLvl = 4'd1, StBRd = 4'd2,
    StBAcc = 4'd4, StBWr = 4'd5, StQ0 = 4'd6, StQ1 = 4'd7,
    StQ2 = 4'd8, StQRd = 4'd9, StQAcc = 4'd10, StQ3 = 4'd11;

  localparam int unsigned LevelSlotsL = hiz_pkg::LevelSlots;

  logic [3:0] st_q;
  logic [8:0] w_q, h_q;
  logic       pv_q;
  logic [16:0] loaded_q;
  logic [AB-1:0] base_q [LevelSlotsL];
  logic [8:0] lw_q [LevelSlotsL];
  logic [8:0] lh_q [LevelSlotsL];
  logic [3:0] lcnt_q;
  logic       lay_q;
  logic [3:0] lay_i_q;
  logic [AB-1:0] lay_tot_q;
  logic [8:0] lay_w_q, lay_h_q;

  logic          ov_q;
  logic [DB-1:0] od_depth_q;
  logic [1:0]    od_status_q;

  logic [3:0]  lvl_q;
  logic [8:0]  x_q, y_q, x0_q, x1_q, y1_q;
  logic [1:0]  ph_q;
  logic [DB-1:0] best_q;
  logic [16:0] u0_q, u1_q, v0_q, v1_q;

  logic          we;
  logic [AB-1:0] addr;
  logic [DB-1:0] wdata, rdata;

  hiz_store #(.AddrBits(AB), .Depth(StoreSize), .DataBits(DB)) u_store (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // input field unpack
  logic         in_cmd, in_last;
  logic [DB-1:0] in_depth;
  assign in_cmd   = s_axis_tuser;
  assign in_depth = s_axis_tdata[23:0];
  assign in_last  = s_axis_tlast;

  function automatic logic [16:0] edge_clamp(input logic [17:0] e);
    if (e[17]) return 17'd0;
    if (e > 18'd65536) return 17'd65536;
    return e[16:0];
  endfunction

  // texel coordinate from q16 edge and level size
  function automatic logic [8:0] tex(input logic [16:0] e, input logic [8:0] s);
    logic [25:0] p;
    p = e * s;
    if (p[25:16] > {1'b0, s - 9'd1}) return s - 9'd1;
    return p[24:16];
  endfunction

  logic [16:0] expected;
  assign expected = 17'(w_q * h_q);
  assign s_axis_tready = (st_q == StIdle) && !ov_q && !lay_q;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // build geometry of the current target level
  logic [8:0] pw, ph, cw, ch, sx, sy;
  always_comb begin
    pw = lw_q[lvl_q - 4'd1];
    ph = lh_q[lvl_q - 4'd1];
    cw = lw_q[lvl_q];
    ch = lh_q[lvl_q];
    sx = {x_q[7:0], 1'b0} + {8'd0, ph_q[0]};
    sy = {y_q[7:0], 1'b0} + {8'd0, ph_q[1]};
    if (sx > pw - 9'd1) sx = pw - 9'd1;
    if (sy > ph - 9'd1) sy = ph - 9'd1;
  end

  always_comb begin
    we = 1'b0;
    addr = '0;
    wdata = best_q;
    if (acc && in_cmd == hiz_pkg::CmdLoad) begin
      we = loaded_q < expected;
      addr = AB'(loaded_q);
      wdata = in_depth;
    end else if (st_q == StBRd) begin
      addr = base_q[lvl_q - 4'd1] + AB'(sy * pw) + AB'(sx);
    end else if (st_q == StBWr) begin
      we = 1'b1;
      addr = base_q[lvl_q] + AB'(y_q * cw) + AB'(x_q);
    end else if (st_q == StQRd) begin
      addr = base_q[lvl_q] + AB'(y_q * lw_q[lvl_q]) + AB'(x_q);
    end
  end

  logic [16:0] du, dv, mm;
  logic [25:0] prod;
  always_comb begin
    du = u1_q - u0_q;
    dv = v1_q - v0_q;
    mm = du > dv ? du : dv;
    prod = mm * w_q;
  end

  // level from bit length of m, then aspect floor, then clamp
  logic [3:0] lv_m, lv_a, lv_f;
  always_comb begin
    lv_m = '0;
    for (int b = 16; b < 26; b++) begin
      if (prod[b]) lv_m = 4'(b - 16);
    end
    lv_a = '0;
    for (int a = 0; a < 9; a++) begin
      if (({9'd0, h_q} << (a + 1)) <= {9'd0, w_q}) lv_a = 4'(a + 1);
    end
    lv_f = lv_m > lv_a ? lv_m : lv_a;
    if (lv_f > lcnt_q - 4'd1) lv_f = lcnt_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      w_q <= 9'(hiz_pkg::MaxWidth);
      h_q <= 9'(hiz_pkg::MaxHeight);
      pv_q <= 1'b0;
      loaded_q <= '0;
      ov_q <= 1'b0;
      lay_q <= 1'b1;
      lay_i_q <= '0;
      lay_tot_q <= '0;
      lay_w_q <= 9'(hiz_pkg::MaxWidth);
      lay_h_q <= 9'(hiz_pkg::MaxHeight);
      lcnt_q <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      if (cfg_wr_en_i && (cfg_index_i == hiz_pkg::CfgWidth ||
                          cfg_index_i == hiz_pkg::CfgHeight)) begin
        // saturate into range, restart layout, drop the pyramid
        if (cfg_index_i == hiz_pkg::CfgWidth) begin
          w_q <= cfg_data_i == 0 ? 9'd1 :
                 (cfg_data_i > 9'(hiz_pkg::MaxWidth) ? 9'(hiz_pkg::MaxWidth) : cfg_data_i);
          lay_w_q <= cfg_data_i == 0 ? 9'd1 :
                 (cfg_data_i > 9'(hiz_pkg::MaxWidth) ? 9'(hiz_pkg::MaxWidth) : cfg_data_i);
          lay_h_q <= h_q;
        end else begin
          h_q <= cfg_data_i == 0 ? 9'd1 :
                 (cfg_data_i > 9'(hiz_pkg::MaxHeight) ? 9'(hiz_pkg::MaxHeight) : cfg_data_i);
          lay_h_q <= cfg_data_i == 0 ? 9'd1 :
                 (cfg_data_i > 9'(hiz_pkg::MaxHeight) ? 9'(hiz_pkg::MaxHeight) : cfg_data_i);
          lay_w_q <= w_q;
        end
        pv_q <= 1'b0;
        loaded_q <= '0;
        lay_q <= 1'b1;
        lay_i_q <= '0;
        lay_tot_q <= '0;
        lcnt_q <= '0;
      end else if (lay_q) begin
        // one level of the layout per cycle
        lw_q[lay_i_q] <= lay_w_q;
        lh_q[lay_i_q] <= lay_h_q;
        base_q[lay_i_q] <= lay_tot_q;
        lay_tot_q <= lay_tot_q + AB'(lay_w_q * lay_h_q);
        lcnt_q <= lay_i_q + 4'd1;
        lay_w_q <= lay_w_q > 9'd1 ? lay_w_q >> 1 : 9'd1;
        lay_h_q <= lay_h_q > 9'd1 ? lay_h_q >> 1 : 9'd1;
        lay_i_q <= lay_i_q + 4'd1;
        if (lay_w_q <= 9'd1 && lay_h_q <= 9'd1) lay_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: begin
          if (acc) begin
            if (in_cmd == hiz_pkg::CmdQuery) begin
              u0_q <= edge_clamp(s_axis_tdata[41:24]);
              v0_q <= edge_clamp(s_axis_tdata[59:42]);
              u1_q <= edge_clamp(s_axis_tdata[77:60]);
              v1_q <= edge_clamp(s_axis_tdata[95:78]);
              st_q <= StQ0;
            end else begin
              if (loaded_q == 0) pv_q <= 1'b0;
              if (in_last) begin
                loaded_q <= '0;
                if (loaded_q + 17'd1 < expected) begin
                  od_depth_q <= '0;
                  od_status_q <= hiz_pkg::StatusRejected;
                  ov_q <= 1'b1;
                end else begin
                  lvl_q <= 4'd1;
                  st_q <= StBLvl;
                end
              end else if (loaded_q < expected) begin
                loaded_q <= loaded_q + 17'd1;
              end
            end
          end
        end
        StBLvl: begin
          if (lvl_q >= lcnt_q) begin
            pv_q <= 1'b1;
            od_depth_q <= '0;
            od_status_q <= hiz_pkg::StatusBuilt;
            ov_q <= 1'b1;
            st_q <= StIdle;
          end else begin
            x_q <= '0; y_q <= '0; ph_q <= '0; best_q <= '0;
            st_q <= StBRd;
          end
        end
        StBRd: st_q <= StBAcc;
        StBAcc: begin
          if (rdata > best_q) best_q <= rdata;
          ph_q <= ph_q + 2'd1;
          st_q <= ph_q == 2'd3 ? StBWr : StBRd;
        end
        StBWr: begin
          best_q <= '0;
          st_q <= StBRd;
          if (x_q == cw - 9'd1) begin
            x_q <= '0;
            if (y_q == ch - 9'd1) begin
              lvl_q <= lvl_q + 4'd1;
              st_q <= StBLvl;
            end else begin
              y_q <= y_q + 9'd1;
            end
          end else begin
            x_q <= x_q + 9'd1;
          end
        end
        StQ0: begin
          if (u1_q < u0_q) begin u0_q <= u1_q; u1_q <= u0_q; end
          if (v1_q < v0_q) begin v0_q <= v1_q; v1_q <= v0_q; end
          st_q <= StQ1;
        end
        StQ1: begin
          // level chosen here, texel bounds from it in StQ2
          lvl_q <= lv_f;
          st_q <= StQ2;
        end
        StQ2: begin
          x0_q <= tex(u0_q, lw_q[lvl_q]);
          x1_q <= tex(u1_q, lw_q[lvl_q]);
          x_q  <= tex(u0_q, lw_q[lvl_q]);
          y_q  <= tex(v0_q, lh_q[lvl_q]);
          y1_q <= tex(v1_q, lh_q[lvl_q]);
          best_q <= '0;
          if (!pv_q) begin
            od_depth_q <= {DB{1'b1}};
            od_status_q <= hiz_pkg::StatusQuery;
            ov_q <= 1'b1;
            st_q <= StIdle;
          end else begin
            st_q <= StQRd;
          end
        end
        StQRd: st_q <= StQAcc;
        StQAcc: begin
          if (rdata > best_q) best_q <= rdata;
          st_q <= StQRd;
          if (x_q == x1_q) begin
            x_q <= x0_q;
            if (y_q == y1_q) st_q <= StQ3;
            else y_q <= y_q + 9'd1;
          end else begin
            x_q <= x_q + 9'd1;
          end
        end
        StQ3: begin
          od_depth_q <= best_q;
          od_status_q <= hiz_pkg::StatusQuery;
          ov_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_depth_q;
  assign m_axis_tuser  = od_status_q;
endmodule

/* hdl/hiz_checker.sv */
// hiz_checker: port-level assertions for hiz_max_depth_pyramid
// depends on hiz_pkg and the top level ports; bound below
module hiz_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [23:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result word dropped while stalled");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= hiz_pkg::StatusRejected)
    else $error("bad status code");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != hiz_pkg::StatusQuery |-> m_axis_tdata == 24'd0)
    else $error("status word carries depth");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
endmodule

bind hiz_max_depth_pyramid hiz_checker u_hiz_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
